// ----- design/hvl_pkg.sv -----
// HAVAL engine package: shared types, constants, round tables and boolean functions.
// Used by every module of the engine; depends on nothing.
`default_nettype none
package hvl_pkg;

    localparam int unsigned NUM_WORDS = 32;
    localparam int unsigned WIDX_W    = 5;
    localparam logic [7:0]  PAD_BYTE  = 8'h01;
    localparam logic [6:0]  PAD_LIMIT = 7'd118;
    localparam int unsigned DEF_PASSES = 3;
    localparam int unsigned DEF_SEL    = 4;

    // Configuration register indexes.
    localparam logic [0:0] REG_PASS   = 1'b0;
    localparam logic [0:0] REG_DIGEST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FEED,
        ST_PADBYTE,
        ST_FOLD,
        ST_EMIT,
        ST_WAIT
    } hvl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       wr_byte;    // write byte_val at position pos
        logic [7:0] byte_val;
        logic       cnt_add;    // add 8 to the bit counter
        logic       load_work;  // copy chain into work registers
        logic       round;      // run one round
        logic [2:0] pass_idx;
        logic [4:0] round_idx;
        logic       feed;       // add work registers to chain
        logic       fold;
        logic       restart;
        logic       latch_len;
    } hvl_cmd_t;

    typedef struct packed {
        logic [6:0] pos;        // byte position in the block
        logic [63:0] len;       // latched message length
    } hvl_stat_t;

    localparam logic [31:0] IV [8] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89};

    localparam logic [31:0] RCONST [4][32] = '{
      '{32'h452821E6,32'h38D01377,32'hBE5466CF,32'h34E90C6C,32'hC0AC29B7,32'hC97C50DD,
        32'h3F84D5B5,32'hB5470917,32'h9216D5D9,32'h8979FB1B,32'hD1310BA6,32'h98DFB5AC,
        32'h2FFD72DB,32'hD01ADFB7,32'hB8E1AFED,32'h6A267E96,32'hBA7C9045,32'hF12C7F99,
        32'h24A19947,32'hB3916CF7,32'h0801F2E2,32'h858EFC16,32'h636920D8,32'h71574E69,
        32'hA458FEA3,32'hF4933D7E,32'h0D95748F,32'h728EB658,32'h718BCD58,32'h82154AEE,
        32'h7B54A41D,32'hC25A59B5},
      '{32'h9C30D539,32'h2AF26013,32'hC5D1B023,32'h286085F0,32'hCA417918,32'hB8DB38EF,
        32'h8E79DCB0,32'h603A180E,32'h6C9E0E8B,32'hB01E8A3E,32'hD71577C1,32'hBD314B27,
        32'h78AF2FDA,32'h55605C60,32'hE65525F3,32'hAA55AB94,32'h57489862,32'h63E81440,
        32'h55CA396A,32'h2AAB10B6,32'hB4CC5C34,32'h1141E8CE,32'hA15486AF,32'h7C72E993,
        32'hB3EE1411,32'h636FBC2A,32'h2BA9C55D,32'h741831F6,32'hCE5C3E16,32'h9B87931E,
        32'hAFD6BA33,32'h6C24CF5C},
      '{32'h7A325381,32'h28958677,32'h3B8F4898,32'h6B4BB9AF,32'hC4BFE81B,32'h66282193,
        32'h61D809CC,32'hFB21A991,32'h487CAC60,32'h5DEC8032,32'hEF845D5D,32'hE98575B1,
        32'hDC262302,32'hEB651B88,32'h23893E81,32'hD396ACC5,32'h0F6D6FF3,32'h83F44239,
        32'h2E0B4482,32'hA4842004,32'h69C8F04A,32'h9E1F9B5E,32'h21C66842,32'hF6E96C9A,
        32'h670C9C61,32'hABD388F0,32'h6A51A0D2,32'hD8542F68,32'h960FA728,32'hAB5133A3,
        32'h6EEF0B6C,32'h137A3BE4},
      '{32'hBA3BF050,32'h7EFB2A98,32'hA1F1651D,32'h39AF0176,32'h66CA593E,32'h82430E88,
        32'h8CEE8619,32'h456F9FB4,32'h7D84A5C3,32'h3B8B5EBE,32'hE06F75D8,32'h85C12073,
        32'h401A449F,32'h56C16AA6,32'h4ED3AA62,32'h363F7706,32'h1BFEDF72,32'h429B023D,
        32'h37D0D724,32'hD00A1248,32'hDB0FEAD3,32'h49F1C09B,32'h075372C9,32'h80991B7B,
        32'h25D479D8,32'hF6E8DEF7,32'hE3FE501A,32'hB6794C3B,32'h976CE0BD,32'h04C006BA,
        32'hC1A94FB6,32'h409F60C4}};

    localparam logic [4:0] WORD_ORDER [4][32] = '{
      '{5'd5,5'd14,5'd26,5'd18,5'd11,5'd28,5'd7,5'd16,5'd0,5'd23,5'd20,5'd22,5'd1,5'd10,
        5'd4,5'd8,5'd30,5'd3,5'd21,5'd9,5'd17,5'd24,5'd29,5'd6,5'd19,5'd12,5'd15,5'd13,
        5'd2,5'd25,5'd31,5'd27},
      '{5'd19,5'd9,5'd4,5'd20,5'd28,5'd17,5'd8,5'd22,5'd29,5'd14,5'd25,5'd12,5'd24,5'd30,
        5'd16,5'd26,5'd31,5'd15,5'd7,5'd3,5'd1,5'd0,5'd18,5'd27,5'd13,5'd6,5'd21,5'd10,
        5'd23,5'd11,5'd5,5'd2},
      '{5'd24,5'd4,5'd0,5'd14,5'd2,5'd7,5'd28,5'd23,5'd26,5'd6,5'd30,5'd20,5'd18,5'd25,
        5'd19,5'd3,5'd22,5'd11,5'd31,5'd21,5'd8,5'd27,5'd12,5'd9,5'd1,5'd29,5'd5,5'd15,
        5'd17,5'd10,5'd16,5'd13},
      '{5'd27,5'd3,5'd21,5'd26,5'd17,5'd11,5'd20,5'd29,5'd19,5'd0,5'd12,5'd7,5'd13,5'd8,
        5'd31,5'd10,5'd5,5'd9,5'd14,5'd30,5'd18,5'd6,5'd28,5'd24,5'd2,5'd23,5'd16,5'd22,
        5'd4,5'd1,5'd25,5'd15}};

    localparam logic [2:0] ARG_MAP [3][5][7] = '{
      '{'{3'd1,3'd0,3'd3,3'd5,3'd6,3'd2,3'd4},'{3'd4,3'd2,3'd1,3'd0,3'd5,3'd3,3'd6},
        '{3'd6,3'd1,3'd2,3'd3,3'd4,3'd5,3'd0},'{3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
        '{3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0}},
      '{'{3'd2,3'd6,3'd1,3'd4,3'd5,3'd3,3'd0},'{3'd3,3'd5,3'd2,3'd0,3'd1,3'd6,3'd4},
        '{3'd1,3'd4,3'd3,3'd6,3'd0,3'd2,3'd5},'{3'd6,3'd4,3'd0,3'd5,3'd2,3'd1,3'd3},
        '{3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0}},
      '{'{3'd3,3'd4,3'd1,3'd0,3'd5,3'd2,3'd6},'{3'd6,3'd2,3'd1,3'd0,3'd3,3'd4,3'd5},
        '{3'd2,3'd6,3'd0,3'd4,3'd3,3'd1,3'd5},'{3'd1,3'd5,3'd3,3'd2,3'd0,3'd4,3'd6},
        '{3'd2,3'd5,3'd0,3'd6,3'd4,3'd3,3'd1}}};

    // Clamp the pass count to three..five.
    function automatic logic [2:0] eff_passes(input logic [2:0] p);
        logic [2:0] r;
        begin
            r = p;
            if (p < 3'd3) r = 3'd3;
            if (p > 3'd5) r = 3'd5;
            return r;
        end
    endfunction

    function automatic logic [2:0] eff_sel(input logic [2:0] s);
        return (s > 3'd4) ? 3'd4 : s;
    endfunction

    function automatic logic [31:0] bool_fn(input logic [2:0] f, input logic [31:0] x6,
        input logic [31:0] x5, input logic [31:0] x4, input logic [31:0] x3,
        input logic [31:0] x2, input logic [31:0] x1, input logic [31:0] x0);
        logic [31:0] r;
        begin
            case (f)
                3'd0: r = (x1&x4)^(x2&x5)^(x3&x6)^(x0&x1)^x0;
                3'd1: r = (x1&x2&x3)^(x2&x4&x5)^(x1&x2)^(x1&x4)^(x2&x6)^(x3&x5)^
                          (x4&x5)^(x0&x2)^x0;
                3'd2: r = (x1&x2&x3)^(x1&x4)^(x2&x5)^(x3&x6)^(x0&x3)^x0;
                3'd3: r = (x1&x2&x3)^(x2&x4&x5)^(x3&x4&x6)^(x1&x4)^(x2&x6)^(x3&x4)^
                          (x3&x5)^(x3&x6)^(x4&x5)^(x4&x6)^(x0&x4)^x0;
                default: r = (x1&x4)^(x2&x5)^(x3&x6)^(x0&x1&x2&x3)^(x0&x5)^x0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/haval_hash_engine_unit.sv -----
// HAVAL hash engine top level: configuration registers, controller and datapath.
// Depends on hvl_pkg, hvl_ctrl and hvl_datapath.
//
// Takes at most one message byte per item and returns the HAVAL digest (3, 4 or 5 passes,
// 128 to 256 bits) as 4 to 8 words after the item marked tlast. A plain byte passes
// through a wait state before the next item is taken; the byte that fills a 128-byte block
// starts a compression that runs one round per cycle through a single round unit. The finish
// writes the padding and trailer one byte per cycle, held while a filled block compresses
// (11 to 138 bytes, with one or two block compressions), folds and then gives one digest
// word per cycle as the output side accepts them.
`default_nettype none
module haval_hash_engine_unit
    import hvl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // byte_present
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // digest_word[31:0], word_number[34:32], zero fill
    output logic             m_tlast,   // final_word
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);

    logic [2:0]  pass_reg, sel_reg;
    logic [2:0]  passes, sel;
    hvl_cmd_t    cmd;
    hvl_stat_t   stat;
    logic [2:0]  out_idx;
    logic [31:0] out_word;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= 3'(DEF_PASSES);
            sel_reg <= 3'(DEF_SEL);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PASS:   pass_reg <= cfg_data;
                REG_DIGEST: sel_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign passes = eff_passes(pass_reg);
    assign sel = eff_sel(sel_reg);
    assign m_tdata = {5'd0, out_idx, out_word};

    hvl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .in_present(s_tuser), .in_last(s_tlast),
        .passes(passes), .sel(sel), .stat(stat), .cmd(cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_idx(out_idx), .out_last(m_tlast)
    );

    hvl_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .passes(passes), .sel(sel),
        .out_idx(out_idx), .stat(stat), .out_word(out_word)
    );

endmodule
`default_nettype wire

// ----- design/hvl_datapath.sv -----
// HAVAL datapath: block buffer, bit counter, work and chain registers, round and fold logic.
// Depends on hvl_pkg; driven by hvl_ctrl through hvl_cmd_t.
`default_nettype none
module hvl_datapath
    import hvl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hvl_cmd_t    cmd,
    input  wire logic [2:0]  passes,
    input  wire logic [2:0]  sel,
    input  wire logic [2:0]  out_idx,
    output hvl_stat_t        stat,
    output logic [31:0]      out_word
);

    logic [31:0] blk_mem [NUM_WORDS];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [63:0] cnt_reg;
    logic [63:0] len_reg;
    logic [31:0] s7, s6, s5, s4;
    logic [31:0] m_word;
    logic [2:0]  psel;
    logic [2:0]  pm1;

    assign stat.pos = cnt_reg[9:3];
    assign stat.len = len_reg;
    assign out_word = chain_reg[out_idx];
    assign psel = passes - 3'd3;
    assign pm1 = cmd.pass_idx - 3'd1;

    // Byte writes into the block buffer, one byte lane at a time.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            case (cnt_reg[4:3])
                2'd0: blk_mem[cnt_reg[9:5]][7:0]   <= cmd.byte_val;
                2'd1: blk_mem[cnt_reg[9:5]][15:8]  <= cmd.byte_val;
                2'd2: blk_mem[cnt_reg[9:5]][23:16] <= cmd.byte_val;
                default: blk_mem[cnt_reg[9:5]][31:24] <= cmd.byte_val;
            endcase
        end
    end

    // Message word for this round.
    always_comb
    begin
        if (cmd.pass_idx == 3'd0)
            m_word = blk_mem[cmd.round_idx];
        else
            m_word = blk_mem[WORD_ORDER[pm1[1:0]][cmd.round_idx]];
    end

    // Bit counter and latched length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
                cnt_reg <= '0;
            else if (cmd.cnt_add)
                cnt_reg <= cnt_reg + 64'd8;
            if (cmd.latch_len)
                len_reg <= cnt_reg;
        end
    end

    // One round and the load of the work registers.
    always_comb
    begin
        logic [31:0] a [7];
        logic [31:0] t, k, fr, dr;
        logic [2:0]  r, dst;
        for (int i = 0; i < 8; i++)
            work_next[i] = work_reg[i];
        r = cmd.round_idx[2:0];
        dst = 3'd7 - r;
        for (int j = 0; j < 7; j++)
            a[j] = work_reg[ARG_MAP[psel[1:0]][cmd.pass_idx][j] - r];
        k = (cmd.pass_idx == 3'd0) ? 32'd0 : RCONST[pm1[1:0]][cmd.round_idx];
        fr = bool_fn(cmd.pass_idx, a[0], a[1], a[2], a[3], a[4], a[5], a[6]);
        dr = work_reg[dst];
        t = {fr[6:0], fr[31:7]} + {dr[10:0], dr[31:11]} + m_word + k;
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                work_next[i] = chain_reg[i];
        end
        else if (cmd.round)
            work_next[dst] = t;
    end

    // Chain update: feed-forward, folding and restart.
    always_comb
    begin
        s7 = chain_reg[7];
        s6 = chain_reg[6];
        s5 = chain_reg[5];
        s4 = chain_reg[4];
        for (int i = 0; i < 8; i++)
            chain_next[i] = chain_reg[i];
        if (cmd.restart)
        begin
            for (int i = 0; i < 8; i++)
                chain_next[i] = IV[i];
        end
        else if (cmd.feed)
        begin
            for (int i = 0; i < 8; i++)
                chain_next[i] = chain_reg[i] + work_reg[i];
        end
        else if (cmd.fold)
        begin
            case (sel)
                3'd0:
                begin
                    chain_next[3] = chain_reg[3] + {s7[31:24], s6[23:16], s5[15:8], s4[7:0]};
                    chain_next[2] = chain_reg[2] + {s7[23:16], s6[15:8], s5[7:0], s4[31:24]};
                    chain_next[1] = chain_reg[1] + {s7[15:8], s6[7:0], s5[31:24], s4[23:16]};
                    chain_next[0] = chain_reg[0] + {s7[7:0], s6[31:24], s5[23:16], s4[15:8]};
                end
                3'd1:
                begin
                    chain_next[4] = chain_reg[4] + {12'd0, s7[31:25], s6[24:19], s5[18:12]};
                    chain_next[3] = chain_reg[3] + {13'd0, s7[24:19], s6[18:12], s5[11:6]};
                    chain_next[2] = chain_reg[2] + {13'd0, s7[18:12], s6[11:6], s5[5:0]};
                    chain_next[1] = chain_reg[1] + {13'd0, s7[11:6], s6[5:0], s5[31:25]};
                    chain_next[0] = chain_reg[0] + {13'd0, s7[5:0], s6[31:25], s5[24:19]};
                end
                3'd2:
                begin
                    chain_next[5] = chain_reg[5] + {21'd0, s7[31:26], s6[25:21]};
                    chain_next[4] = chain_reg[4] + {22'd0, s7[25:21], s6[20:16]};
                    chain_next[3] = chain_reg[3] + {21'd0, s7[20:16], s6[15:10]};
                    chain_next[2] = chain_reg[2] + {21'd0, s7[15:10], s6[9:5]};
                    chain_next[1] = chain_reg[1] + {22'd0, s7[9:5], s6[4:0]};
                    chain_next[0] = chain_reg[0] + {21'd0, s7[4:0], s6[31:26]};
                end
                3'd3:
                begin
                    chain_next[6] = chain_reg[6] + {28'd0, s7[3:0]};
                    chain_next[5] = chain_reg[5] + {27'd0, s7[8:4]};
                    chain_next[4] = chain_reg[4] + {28'd0, s7[12:9]};
                    chain_next[3] = chain_reg[3] + {27'd0, s7[17:13]};
                    chain_next[2] = chain_reg[2] + {28'd0, s7[21:18]};
                    chain_next[1] = chain_reg[1] + {27'd0, s7[26:22]};
                    chain_next[0] = chain_reg[0] + {27'd0, s7[31:27]};
                end
                default:
                begin
                end
            endcase
        end
    end

    // Chain and work registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
                work_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
                work_reg[i] <= work_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/hvl_ctrl.sv -----
// HAVAL controller: sequences byte intake, compression, padding, folding and word output.
// Depends on hvl_pkg; commands hvl_datapath.
`default_nettype none
module hvl_ctrl
    import hvl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_present,
    input  wire logic        in_last,
    input  wire logic [2:0]  passes,
    input  wire logic [2:0]  sel,
    input  wire hvl_stat_t   stat,
    output hvl_cmd_t         cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_idx,
    output logic             out_last
);

    hvl_state_t state_reg, state_next;
    logic [2:0] pass_reg, pass_next;
    logic [4:0] rnd_reg, rnd_next;
    logic       fin_reg, fin_next;      // finishing the message
    logic [3:0] pad_reg, pad_next;      // trailer byte index, 0 means padding zone
    logic [2:0] oidx_reg, oidx_next;
    logic       first_reg, first_next;  // next pad byte is the 0x01 marker
    logic [7:0] pad_byte;
    logic [9:0] fpt;
    logic [2:0] nlast;

    assign fpt = 10'd128 + {2'd0, sel, 5'd0};
    assign nlast = 3'd3 + sel;
    assign out_idx = oidx_reg;
    assign out_last = (oidx_reg == nlast);

    // Byte to append in the padding sequence.
    always_comb
    begin
        pad_byte = 8'd0;
        if (first_reg)
            pad_byte = PAD_BYTE;
        else if (pad_reg == 4'd1)
            pad_byte = {fpt[1:0], passes, 3'd1};
        else if (pad_reg == 4'd2)
            pad_byte = fpt[9:2];
        else if (pad_reg >= 4'd3)
            pad_byte = stat.len[8 * (pad_reg - 4'd3) +: 8];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        pass_next = pass_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        pad_next = pad_reg;
        oidx_next = oidx_reg;
        first_next = first_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fin_next = in_last;
                    first_next = 1'b1;
                    pad_next = 4'd0;
                    if (in_present && stat.pos == 7'd127)
                        state_next = ST_LOAD;
                    else if (in_last)
                        state_next = ST_PADBYTE;
                    else
                        state_next = ST_WAIT;
                end
            end
            ST_WAIT:
                state_next = ST_IDLE;
            ST_LOAD:
            begin
                pass_next = '0;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 5'd1;
                if (rnd_reg == 5'd31)
                begin
                    pass_next = pass_reg + 3'd1;
                    if (pass_reg + 3'd1 == passes)
                        state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (pad_reg == 4'd11)
                    state_next = ST_FOLD;
                else
                    state_next = ST_PADBYTE;
            end
            ST_PADBYTE:
            begin
                first_next = 1'b0;
                if (pad_reg != 4'd0 || stat.pos == PAD_LIMIT - 7'd1 || (first_reg &&
                    stat.pos == PAD_LIMIT - 7'd1))
                    pad_next = pad_reg + 4'd1;
                if (stat.pos == 7'd127)
                    state_next = ST_LOAD;
                else if (pad_reg == 4'd10)
                begin
                    pad_next = 4'd11;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                oidx_next = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == nlast)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd.pass_idx = pass_reg;
        cmd.round_idx = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_present)
                begin
                    cmd.wr_byte = 1'b1;
                    cmd.byte_val = in_byte;
                    cmd.cnt_add = 1'b1;
                end
            end
            ST_LOAD:
                cmd.load_work = 1'b1;
            ST_ROUND:
                cmd.round = 1'b1;
            ST_FEED:
                cmd.feed = 1'b1;
            ST_PADBYTE:
            begin
                if (first_reg)
                    cmd.latch_len = 1'b1;
                cmd.wr_byte = 1'b1;
                cmd.byte_val = pad_byte;
                cmd.cnt_add = 1'b1;
            end
            ST_FOLD:
                cmd.fold = 1'b1;
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready && oidx_reg == nlast)
                    cmd.restart = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            pad_reg <= '0;
            oidx_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg <= pass_next;
            rnd_reg <= rnd_next;
            fin_reg <= fin_next;
            pad_reg <= pad_next;
            oidx_reg <= oidx_next;
            first_reg <= first_next;
        end
    end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for haval_hash_engine_unit: drives message bytes, predicts digests.
// Depends on hvl_pkg for register indexes and the round tables; needs only the design.
`timescale 1ns / 100ps

module tb_top;
    import hvl_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE = 600;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } digest_item_t;

    // Scoreboard: a software HAVAL engine plus the queue of digest words it predicts.
    class haval_scoreboard;
        logic [31:0] chain [8];
        logic [31:0] blk [32];
        logic [63:0] bits;
        logic [2:0]  pass_reg;
        logic [2:0]  sel_reg;
        digest_item_t digest_q [$];
        int errors;

        function new();
            chain = IV;
            foreach (blk[i]) blk[i] = '0;
            bits = '0;
            pass_reg = 3'd3;
            sel_reg = 3'd4;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void write_reg(logic [0:0] idx, logic [2:0] val);
            if (idx == REG_PASS) pass_reg = val;
            else sel_reg = val;
        endfunction

        function int passes();
            if (pass_reg < 3) return 3;
            if (pass_reg > 5) return 5;
            return pass_reg;
        endfunction

        function int digest_sel();
            return (sel_reg > 4) ? 4 : sel_reg;
        endfunction

        function logic [31:0] rotr(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function logic [31:0] mix(int f, logic [31:0] x6, logic [31:0] x5, logic [31:0] x4,
                                  logic [31:0] x3, logic [31:0] x2, logic [31:0] x1,
                                  logic [31:0] x0);
            case (f)
                0: return (x1&x4)^(x2&x5)^(x3&x6)^(x0&x1)^x0;
                1: return (x1&x2&x3)^(x2&x4&x5)^(x1&x2)^(x1&x4)^(x2&x6)^(x3&x5)^
                          (x4&x5)^(x0&x2)^x0;
                2: return (x1&x2&x3)^(x1&x4)^(x2&x5)^(x3&x6)^(x0&x3)^x0;
                3: return (x1&x2&x3)^(x2&x4&x5)^(x3&x4&x6)^(x1&x4)^(x2&x6)^(x3&x4)^
                          (x3&x5)^(x3&x6)^(x4&x5)^(x4&x6)^(x0&x4)^x0;
                default: return (x1&x4)^(x2&x5)^(x3&x6)^(x0&x1&x2&x3)^(x0&x5)^x0;
            endcase
        endfunction

        // One block compression with the current pass count.
        function void compress();
            logic [31:0] w [8];
            logic [31:0] a [7];
            logic [31:0] msg;
            logic [31:0] k;
            int p;
            int r;
            int dst;
            p = passes();
            w = chain;
            for (int f = 0; f < p; f++) begin
                for (int i = 0; i < 32; i++) begin
                    r = i % 8;
                    dst = (15 - r) % 8;
                    for (int j = 0; j < 7; j++) a[j] = w[(ARG_MAP[p-3][f][j] + 8 - r) % 8];
                    if (f == 0) begin
                        msg = blk[i];
                        k = '0;
                    end
                    else begin
                        msg = blk[WORD_ORDER[f-1][i]];
                        k = RCONST[f-1][i];
                    end
                    w[dst] = rotr(mix(f, a[0], a[1], a[2], a[3], a[4], a[5], a[6]), 7)
                             + rotr(w[dst], 11) + msg + k;
                end
            end
            for (int i = 0; i < 8; i++) chain[i] += w[i];
        endfunction

        // Store a byte at a block position, compressing a full block; returns the next position.
        function int put_at(int pos, logic [7:0] b);
            blk[pos / 4][(pos % 4) * 8 +: 8] = b;
            if (pos == 127) compress();
            return (pos + 1) % 128;
        endfunction

        function void fold(int sel);
            logic [31:0] s [8];
            s = chain;
            if (sel == 0) begin
                s[3] += (s[7] & 32'hFF000000) | (s[6] & 32'h00FF0000) | (s[5] & 32'h0000FF00)
                        | (s[4] & 32'h000000FF);
                s[2] += (((s[7] & 32'h00FF0000) | (s[6] & 32'h0000FF00)
                        | (s[5] & 32'h000000FF)) << 8) | ((s[4] & 32'hFF000000) >> 24);
                s[1] += (((s[7] & 32'h0000FF00) | (s[6] & 32'h000000FF)) << 16)
                        | (((s[5] & 32'hFF000000) | (s[4] & 32'h00FF0000)) >> 16);
                s[0] += ((s[7] & 32'h000000FF) << 24) | (((s[6] & 32'hFF000000)
                        | (s[5] & 32'h00FF0000) | (s[4] & 32'h0000FF00)) >> 8);
            end
            else if (sel == 1) begin
                s[4] += ((s[7] & 32'hFE000000) | (s[6] & 32'h01F80000)
                        | (s[5] & 32'h0007F000)) >> 12;
                s[3] += ((s[7] & 32'h01F80000) | (s[6] & 32'h0007F000)
                        | (s[5] & 32'h00000FC0)) >> 6;
                s[2] += (s[7] & 32'h0007F000) | (s[6] & 32'h00000FC0) | (s[5] & 32'h0000003F);
                s[1] += rotr((s[7] & 32'h00000FC0) | (s[6] & 32'h0000003F)
                        | (s[5] & 32'hFE000000), 25);
                s[0] += rotr((s[7] & 32'h0000003F) | (s[6] & 32'hFE000000)
                        | (s[5] & 32'h01F80000), 19);
            end
            else if (sel == 2) begin
                s[5] += ((s[7] & 32'hFC000000) | (s[6] & 32'h03E00000)) >> 21;
                s[4] += ((s[7] & 32'h03E00000) | (s[6] & 32'h001F0000)) >> 16;
                s[3] += ((s[7] & 32'h001F0000) | (s[6] & 32'h0000FC00)) >> 10;
                s[2] += ((s[7] & 32'h0000FC00) | (s[6] & 32'h000003E0)) >> 5;
                s[1] += (s[7] & 32'h000003E0) | (s[6] & 32'h0000001F);
                s[0] += rotr((s[7] & 32'h0000001F) | (s[6] & 32'hFC000000), 26);
            end
            else if (sel == 3) begin
                s[6] += s[7] & 32'h0000000F;
                s[5] += (s[7] >> 4) & 32'h0000001F;
                s[4] += (s[7] >> 9) & 32'h0000000F;
                s[3] += (s[7] >> 13) & 32'h0000001F;
                s[2] += (s[7] >> 18) & 32'h0000000F;
                s[1] += (s[7] >> 22) & 32'h0000001F;
                s[0] += (s[7] >> 27) & 32'h0000001F;
            end
            chain = s;
        endfunction

        // Accepted input item: absorb the byte, and on the final item pad and predict.
        function void note_input(logic [7:0] data, logic present, logic last);
            logic [63:0] len;
            int sel;
            int fpt;
            int pos;
            int pad;
            int nwords;
            digest_item_t d;
            if (present) begin
                void'(put_at(int'(bits[9:3]), data));
                bits += 64'd8;
            end
            if (!last) return;
            len = bits;
            sel = digest_sel();
            fpt = 128 + 32 * sel;
            pos = int'(len[9:3]);
            pad = (pos < 118) ? 118 - pos : 246 - pos;
            pos = put_at(pos, 8'h01);
            for (int i = 1; i < pad; i++) pos = put_at(pos, 8'h00);
            pos = put_at(pos, 8'(1 | (passes() << 3) | ((fpt % 4) << 6)));
            pos = put_at(pos, 8'(fpt >> 2));
            for (int i = 0; i < 8; i++) pos = put_at(pos, len[8*i +: 8]);
            fold(sel);
            nwords = 4 + sel;
            for (int i = 0; i < nwords; i++) begin
                d.word = chain[i];
                d.num = 3'(i);
                d.last = (i + 1 == nwords);
                digest_q.push_back(d);
            end
            chain = IV;
            bits = '0;
        endfunction

        // Accepted digest word: compare with the oldest prediction.
        function void check_result(logic [39:0] tdata, logic tlast);
            digest_item_t d;
            if (digest_q.size() == 0) begin
                report($sformatf("unexpected digest word %h", tdata[31:0]));
                return;
            end
            d = digest_q.pop_front();
            if (tdata[31:0] !== d.word)
                report($sformatf("word %0d: got %h, want %h", d.num, tdata[31:0], d.word));
            if (tdata[34:32] !== d.num)
                report($sformatf("word number: got %0d, want %0d", tdata[34:32], d.num));
            if (tdata[39:35] !== 5'd0)
                report($sformatf("fill bits not zero: %b", tdata[39:35]));
            if (tlast !== d.last)
                report($sformatf("word %0d: last flag %b, want %b", d.num, tlast, d.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [2:0]  cfg_data;

    haval_scoreboard digest_sb;
    int cycles;
    int items_sent;
    bit no_gaps;

    haval_hash_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Cycle counter and run-time guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Output side: random stalls, check every accepted digest word.
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
                stall = gap_len();
            end
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) digest_sb.check_result(m_tdata, m_tlast);
        end
    end

    // Send one input item and hand it to the scoreboard once accepted.
    task automatic send_item(logic [7:0] data, logic present, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = data;
        s_tuser = present;
        s_tlast = last;
        do @(posedge clk); while (!s_tready);
        digest_sb.note_input(data, present, last);
        if (present || last) items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Let every predicted word drain and the engine settle before touching registers.
    task automatic wait_idle();
        while (digest_sb.digest_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [2:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        digest_sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_mode(logic [2:0] p, logic [2:0] s);
        wait_idle();
        write_cfg(REG_PASS, p);
        write_cfg(REG_DIGEST, s);
    endtask

    // A message of n random bytes; the final item may or may not carry a byte.
    task automatic send_message(int n, bit noise);
        bit last_has_byte;
        last_has_byte = (n > 0) && $urandom_range(1);
        for (int i = 0; i < n - int'(last_has_byte); i++)
        begin
            if (noise && $urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        send_item(8'($urandom), last_has_byte, 1'b1);
    endtask

    initial
    begin
        int len;
        int r;
        digest_sb = new();
        cycles = 0;
        items_sent = 0;
        no_gaps = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PASS;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty finish at reset settings, byte extremes, idle item, finish with byte.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // Out-of-range and in-range pass counts and digest selects, covering each effective value.
        set_mode(3'd0, 3'd0);
        send_item(8'hA5, 1'b1, 1'b1);
        set_mode(3'd7, 3'd7);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        set_mode(3'd4, 3'd1);
        send_item(8'h3C, 1'b1, 1'b1);
        set_mode(3'd5, 3'd2);
        send_item(8'h00, 1'b0, 1'b1);
        set_mode(3'd3, 3'd3);
        send_item(8'hC3, 1'b1, 1'b1);
        set_mode(3'd6, 3'd5);
        send_item(8'h81, 1'b1, 1'b1);
        set_mode(3'd2, 3'd6);
        send_item(8'h7E, 1'b1, 1'b1);

        // Random messages; lengths near the padding and block edges show up often.
        while (items_sent < 200)
        begin
            if ($urandom_range(9) < 4) set_mode(3'($urandom), 3'($urandom));
            no_gaps = ($urandom_range(4) == 0);
            r = $urandom_range(99);
            if (r < 55) len = $urandom_range(12);
            else if (r < 80) len = $urandom_range(60, 13);
            else if (r < 95) len = 116 + $urandom_range(13);
            else len = $urandom_range(260, 200);
            // Keep the total item count close to the planned size.
            if (len > 220 - items_sent) len = 220 - items_sent;
            send_message(len, 1'b1);
        end

        no_gaps = 0;
        wait_idle();
        if (digest_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
